// ----- rtl/clahe_pkg.sv -----
// ----------------------------------------------------------------------------
// clahe_pkg
// Shared types, constants and helpers of the sliding CLAHE pixel equalizer.
// ----------------------------------------------------------------------------
`default_nettype none

package clahe_pkg;

   // Histogram geometry
   localparam int MAX_BINS    = 4096;
   localparam int BIN_BITS    = $clog2(MAX_BINS);
   localparam int CNT_W       = BIN_BITS + 1;
   localparam int COUNT_BITS  = 19;
   localparam int CLIP_PASSES = 5;
   localparam int PASS_W      = $clog2(CLIP_PASSES + 1);

   // Arithmetic widths
   localparam int VALUE_BITS = 16;
   localparam int SUM_W      = COUNT_BITS + BIN_BITS;
   localparam int NUM_W      = SUM_W + VALUE_BITS;
   localparam int FRAC_W     = VALUE_BITS + 1;
   localparam int AMT_W      = 16;
   localparam int CSR_W      = 19;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
   localparam logic [AMT_W:0]        AMOUNT_ONE = 17'd32768;

   // Resolution codes
   localparam logic [1:0] RES_256  = 2'd0;
   localparam logic [1:0] RES_1024 = 2'd1;
   localparam logic [1:0] RES_4096 = 2'd2;

   // Register indexes
   localparam logic [1:0] REG_RESOLUTION = 2'd0;
   localparam logic [1:0] REG_CLIP_LIMIT = 2'd1;
   localparam logic [1:0] REG_BLEND      = 2'd2;

   typedef enum logic [1:0] {
      FUNC_CLEAR  = 2'd0,
      FUNC_ADD    = 2'd1,
      FUNC_REMOVE = 2'd2,
      FUNC_EVAL   = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_UPDATE,
      ST_SWEEP,
      ST_STEP_DIV,
      ST_FRAC_DIV,
      ST_MUL_KEEP,
      ST_MUL_EQ,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [11:0] sample_bin;
      logic [15:0] center_value;
      logic [11:0] center_bin;
   } req_type;

   typedef struct packed {
      logic [15:0] equalized_value;
      logic        degenerate;
   } rsp_type;

   // Log2 of the active bin count, capped at the histogram depth
   function automatic logic [3:0] bins_log2(input logic [1:0] res);
      logic [3:0] l;
      unique case (res)
         RES_1024: l = 4'd10;
         RES_4096: l = 4'd12;
         default:  l = 4'd8;
      endcase
      if (l > 4'(BIN_BITS)) l = 4'(BIN_BITS);
      return l;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/clahe_ram.sv -----
// ----------------------------------------------------------------------------
// clahe_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module clahe_ram #(
   parameter int ADDR_BITS = 12,
   parameter int DATA_BITS = 19
) (
   input  wire logic                 clock,
   input  wire logic                 we,
   input  wire logic [ADDR_BITS-1:0] waddr,
   input  wire logic [DATA_BITS-1:0] wdata,
   input  wire logic [ADDR_BITS-1:0] raddr,
   output logic      [DATA_BITS-1:0] rdata_ff
);

   logic [DATA_BITS-1:0] mem [1 << ADDR_BITS];

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

endmodule

`default_nettype wire

// ----- rtl/clahe_div.sv -----
// ----------------------------------------------------------------------------
// clahe_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module clahe_div
   import clahe_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [SUM_W-1:0] den,
   output logic                  done,
   output logic      [NUM_W-1:0] quo
);

   localparam int ITER_W = $clog2(NUM_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [SUM_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  den_ff, den_in;
   logic [SUM_W:0]    trial;
   logic              ge;

   // Shift one numerator bit into the remainder and try a subtract
   always_comb begin
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      ge      = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      iter_in = iter_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         iter_in = '0;
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[NUM_W-2:0], ge};
         rem_in  = ge ? SUM_W'(trial - {1'b0, den_ff}) : trial[SUM_W-1:0];
         iter_in = iter_ff + 1'b1;
         if (iter_ff == ITER_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      iter_ff <= iter_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

`default_nettype wire

// ----- rtl/sliding_clahe_pixel_equalizer.sv -----
// ----------------------------------------------------------------------------
// sliding_clahe_pixel_equalizer
// Live kernel histogram with clip-limited equalization of the center pixel.
// ----------------------------------------------------------------------------
// One item is handled at a time. Add and remove read, then write back the
// live histogram memory; clear zeroes all MAX_BINS = 4096 bins, one per
// cycle, and after reset the same clearing pass runs before the first
// item is taken (configuration writes are taken throughout). An evaluate
// sweeps the n active bins once per clip pass and once more for the CDF,
// min and total, at most CLIP_PASSES+1 = 6 sweeps; every pass that leaves
// a remainder adds a serial division for the spreading step, the fraction
// may take one more serial division, and the blend follows. The time is
// set by the one-bin-per-cycle memory sweep and the serial divider.
`default_nettype none

module sliding_clahe_pixel_equalizer
   import clahe_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire req_type          req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rsp_type               rsp_data,
   input  wire logic             csr_we,
   input  wire logic [1:0]       csr_index,
   input  wire logic [CSR_W-1:0] csr_wdata
);

   state_type state_ff, state_in;

   // Configuration
   logic [1:0]       resolution_ff, resolution_in;
   logic [CSR_W-1:0] clip_ff, clip_in;
   logic [AMT_W-1:0] blend_ff, blend_in;

   // Sweep control
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                pv_ff, pv_in;
   logic [BIN_BITS-1:0] pa_ff, pa_in;
   logic [PASS_W-1:0]   pass_ff, pass_in;
   logic                final_ff, final_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Item and arithmetic payload
   logic [BIN_BITS-1:0]   sbin_ff, sbin_in;
   logic                  add_ff, add_in;
   logic [3:0]            nlog_ff, nlog_in;
   logic [COUNT_BITS-1:0] lim_ff, lim_in;
   logic [BIN_BITS-1:0]   cbin_ff, cbin_in;
   logic [15:0]           value_ff, value_in;
   logic [AMT_W-1:0]      amt_ff, amt_in;
   logic [SUM_W-1:0]      excess_ff, excess_in;
   logic [SUM_W-1:0]      dist_ff, dist_in;
   logic [CNT_W:0]        next_ff, next_in;
   logic [BIN_BITS-1:0]   left_ff, left_in;
   logic [CNT_W-1:0]      step_ff, step_in;
   logic [SUM_W-1:0]      total_ff, total_in;
   logic [SUM_W-1:0]      cdf_ff, cdf_in;
   logic [COUNT_BITS-1:0] mn_ff, mn_in;
   logic                  found_ff, found_in;
   logic                  degen_ff, degen_in;
   logic [FRAC_W-1:0]     frac_ff, frac_in;
   logic [32:0]           keep_ff, keep_in;
   logic [32:0]           eq_ff, eq_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   // Memory ports
   logic                  live_we, clip_we;
   logic [BIN_BITS-1:0]   live_waddr, live_raddr, clip_waddr, clip_raddr;
   logic [COUNT_BITS-1:0] live_wdata, clip_wdata, live_rdata, clip_rdata;

   // Divider
   logic             div_start, div_done;
   logic [NUM_W-1:0] div_num, div_quo;
   logic [SUM_W-1:0] div_den;

   // Helpers
   logic                  accept;
   logic [CNT_W-1:0]      nbins_now, nbins, mask;
   logic [COUNT_BITS-1:0] rd, x, upd;
   logic [SUM_W:0]        xw;
   logic                  inc;
   logic [SUM_W-1:0]      d_next;
   logic [BIN_BITS-1:0]   r_next;
   logic [33:0]           blend_sum;
   logic [18:0]           blend_res;
   logic [3:0]            req_log;

   clahe_ram #(.ADDR_BITS(BIN_BITS), .DATA_BITS(COUNT_BITS)) u_live (
      .clock    (clock),
      .we       (live_we),
      .waddr    (live_waddr),
      .wdata    (live_wdata),
      .raddr    (live_raddr),
      .rdata_ff (live_rdata)
   );

   clahe_ram #(.ADDR_BITS(BIN_BITS), .DATA_BITS(COUNT_BITS)) u_clip (
      .clock    (clock),
      .we       (clip_we),
      .waddr    (clip_waddr),
      .wdata    (clip_wdata),
      .raddr    (clip_raddr),
      .rdata_ff (clip_rdata)
   );

   clahe_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // Next state, datapath and memory control
   always_comb begin
      accept    = req_valid && (state_ff == ST_IDLE);
      req_log   = bins_log2(resolution_ff);
      nbins_now = CNT_W'(1) << req_log;
      nbins     = CNT_W'(1) << nlog_ff;
      mask      = nbins - 1'b1;

      // Sweep datapath: apply last pass's spread to the bin read back
      rd  = (pass_ff == '0 && !final_ff) ? live_rdata : clip_rdata;
      inc = pv_ff && (left_ff != '0) && ({2'b00, pa_ff} == next_ff);
      xw  = (SUM_W + 1)'(rd) + (SUM_W + 1)'(dist_ff) + (SUM_W + 1)'(inc);
      x   = (xw > (SUM_W + 1)'(COUNT_MAX)) ? COUNT_MAX : xw[COUNT_BITS-1:0];
      d_next = excess_ff >> nlog_ff;
      r_next = excess_ff[BIN_BITS-1:0] & mask[BIN_BITS-1:0];

      // Saturating add or remove on the live histogram
      if (add_ff) begin
         upd = (live_rdata == COUNT_MAX) ? live_rdata : live_rdata + 1'b1;
      end else begin
         upd = (live_rdata == '0) ? live_rdata : live_rdata - 1'b1;
      end

      blend_sum = {1'b0, keep_ff} + {1'b0, eq_ff};
      blend_res = blend_sum[33:15];

      state_in     = state_ff;
      resolution_in = resolution_ff;
      clip_in      = clip_ff;
      blend_in     = blend_ff;
      cnt_in       = cnt_ff;
      pv_in        = 1'b0;
      pa_in        = pa_ff;
      pass_in      = pass_ff;
      final_in     = final_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      sbin_in      = sbin_ff;
      add_in       = add_ff;
      nlog_in      = nlog_ff;
      lim_in       = lim_ff;
      cbin_in      = cbin_ff;
      value_in     = value_ff;
      amt_in       = amt_ff;
      excess_in    = excess_ff;
      dist_in      = dist_ff;
      next_in      = next_ff;
      left_in      = left_ff;
      step_in      = step_ff;
      total_in     = total_ff;
      cdf_in       = cdf_ff;
      mn_in        = mn_ff;
      found_in     = found_ff;
      degen_in     = degen_ff;
      frac_in      = frac_ff;
      keep_in      = keep_ff;
      eq_in        = eq_ff;
      rsp_data_in  = rsp_data_ff;

      live_we    = 1'b0;
      live_waddr = cnt_ff[BIN_BITS-1:0];
      live_wdata = '0;
      live_raddr = cnt_ff[BIN_BITS-1:0];
      clip_we    = 1'b0;
      clip_waddr = pa_ff;
      clip_wdata = x;
      clip_raddr = cnt_ff[BIN_BITS-1:0];
      div_start  = 1'b0;
      div_num    = NUM_W'(nbins);
      div_den    = SUM_W'(r_next);

      // Register writes
      if (csr_we) begin
         unique case (csr_index)
            REG_RESOLUTION: resolution_in = csr_wdata[1:0];
            REG_CLIP_LIMIT: clip_in       = csr_wdata;
            REG_BLEND:      blend_in      = csr_wdata[AMT_W-1:0];
            default:        ;
         endcase
      end

      unique case (state_ff)
         // Zero every live bin, one per cycle
         ST_INIT, ST_CLEAR: begin
            live_we = 1'b1;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MAX_BINS - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            live_raddr = req_data.sample_bin;
            if (accept) begin
               unique case (req_data.func)
                  FUNC_CLEAR: begin
                     cnt_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  FUNC_ADD, FUNC_REMOVE: begin
                     sbin_in = req_data.sample_bin;
                     add_in  = (req_data.func == FUNC_ADD);
                     if (CNT_W'(req_data.sample_bin) < nbins_now) begin
                        state_in = ST_UPDATE;
                     end
                  end
                  default: begin
                     nlog_in  = req_log;
                     lim_in   = (clip_ff == '0) ? COUNT_BITS'(1) : COUNT_BITS'(clip_ff);
                     cbin_in  = (CNT_W'(req_data.center_bin) >= nbins_now) ?
                                BIN_BITS'(nbins_now - 1'b1) : req_data.center_bin;
                     value_in = req_data.center_value;
                     amt_in   = ({1'b0, blend_ff} > AMOUNT_ONE) ?
                                AMT_W'(AMOUNT_ONE) : blend_ff;
                     cnt_in    = '0;
                     pass_in   = '0;
                     final_in  = 1'b0;
                     excess_in = '0;
                     dist_in   = '0;
                     left_in   = '0;
                     next_in   = '0;
                     total_in  = '0;
                     cdf_in    = '0;
                     mn_in     = '0;
                     found_in  = 1'b0;
                     state_in  = ST_SWEEP;
                  end
               endcase
            end
         end

         // Write back the modified live bin
         ST_UPDATE: begin
            live_we    = 1'b1;
            live_waddr = sbin_ff;
            live_wdata = upd;
            state_in   = ST_IDLE;
         end

         ST_SWEEP: begin
            // Issue the next read
            if (cnt_ff < nbins) begin
               pv_in  = 1'b1;
               pa_in  = cnt_ff[BIN_BITS-1:0];
               cnt_in = cnt_ff + 1'b1;
            end
            // Consume the remainder slot at this bin
            if (inc) begin
               next_in = next_ff + (CNT_W + 1)'(step_ff);
               left_in = left_ff - 1'b1;
            end
            // Process the bin read last cycle
            if (pv_ff) begin
               if (!final_ff) begin
                  clip_we = 1'b1;
                  if (x > lim_ff) begin
                     clip_wdata = lim_ff;
                     excess_in  = excess_ff + SUM_W'(x - lim_ff);
                  end
               end else begin
                  total_in = total_ff + SUM_W'(x);
                  if (pa_ff <= cbin_ff) begin
                     cdf_in = cdf_ff + SUM_W'(x);
                  end
                  if (!found_ff && x != '0) begin
                     mn_in    = x;
                     found_in = 1'b1;
                  end
               end
            end else if (cnt_ff == nbins) begin
               // Sweep complete
               if (!final_ff) begin
                  pass_in   = pass_ff + 1'b1;
                  final_in  = (pass_ff == PASS_W'(CLIP_PASSES - 1)) || (excess_ff == '0);
                  dist_in   = d_next;
                  left_in   = r_next;
                  next_in   = '0;
                  excess_in = '0;
                  cnt_in    = '0;
                  if (r_next != '0) begin
                     div_start = 1'b1;
                     state_in  = ST_STEP_DIV;
                  end
               end else begin
                  degen_in = (total_ff == SUM_W'(mn_ff));
                  frac_in  = '0;
                  if (total_ff == SUM_W'(mn_ff)) begin
                     state_in = ST_MUL_KEEP;
                  end else if (cdf_ff > SUM_W'(mn_ff)) begin
                     div_start = 1'b1;
                     div_num   = NUM_W'(cdf_ff - SUM_W'(mn_ff)) << VALUE_BITS;
                     div_den   = total_ff - SUM_W'(mn_ff);
                     state_in  = ST_FRAC_DIV;
                  end else begin
                     state_in = ST_MUL_KEEP;
                  end
               end
            end
         end

         ST_STEP_DIV: begin
            if (div_done) begin
               step_in  = div_quo[CNT_W-1:0];
               state_in = ST_SWEEP;
            end
         end

         ST_FRAC_DIV: begin
            if (div_done) begin
               frac_in  = div_quo[FRAC_W-1:0];
               state_in = ST_MUL_KEEP;
            end
         end

         ST_MUL_KEEP: begin
            keep_in  = 33'(AMOUNT_ONE - {1'b0, amt_ff}) * 33'(value_ff);
            state_in = ST_MUL_EQ;
         end

         ST_MUL_EQ: begin
            eq_in    = 33'(amt_ff) * 33'(frac_ff);
            state_in = ST_OUT;
         end

         // Hold until the output register is free
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.equalized_value = (blend_res > 19'd65535) ?
                                             16'hFFFF : blend_res[15:0];
               rsp_data_in.degenerate = degen_ff;
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         cnt_ff        <= '0;
         pv_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         resolution_ff <= RES_256;
         clip_ff       <= CSR_W'(1);
         blend_ff      <= AMT_W'(AMOUNT_ONE);
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         pv_ff         <= pv_in;
         rsp_valid_ff  <= rsp_valid_in;
         resolution_ff <= resolution_in;
         clip_ff       <= clip_in;
         blend_ff      <= blend_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pa_ff       <= pa_in;
      pass_ff     <= pass_in;
      final_ff    <= final_in;
      sbin_ff     <= sbin_in;
      add_ff      <= add_in;
      nlog_ff     <= nlog_in;
      lim_ff      <= lim_in;
      cbin_ff     <= cbin_in;
      value_ff    <= value_in;
      amt_ff      <= amt_in;
      excess_ff   <= excess_in;
      dist_ff     <= dist_in;
      next_ff     <= next_in;
      left_ff     <= left_in;
      step_ff     <= step_in;
      total_ff    <= total_in;
      cdf_ff      <= cdf_in;
      mn_ff       <= mn_in;
      found_ff    <= found_in;
      degen_ff    <= degen_in;
      frac_ff     <= frac_in;
      keep_ff     <= keep_in;
      eq_ff       <= eq_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- rtl/clahe_checker.sv -----
// ----------------------------------------------------------------------------
// clahe_checker
// Port-level checks of the equalizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module clahe_checker
   import clahe_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("stalled result changed");

   // The clearing pass blocks items right after reset
   a_init_busy: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("item taken during clearing pass");

   // An evaluate or clear keeps the request side stalled after it is taken
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall &&
      (req_data.func == FUNC_EVAL || req_data.func == FUNC_CLEAR) |=> req_stall)
      else $error("long item finished in one cycle");

endmodule

bind sliding_clahe_pixel_equalizer clahe_checker u_clahe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
